/* src/priority_scheduler_with_burst_limit_top_assert.svh */
// Assertion macros for the priority scheduler checker.
`ifndef PRIORITY_SCHEDULER_WITH_BURST_LIMIT_TOP_ASSERT_SVH
`define PRIORITY_SCHEDULER_WITH_BURST_LIMIT_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define PSBL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// Antecedent implies consequent in the following cycle.
`define PSBL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

/* src/psbl_pkg.sv */
// ----------------------------------------------------------------------------
// psbl_pkg
// Types and constants shared by the priority scheduler modules.
// ----------------------------------------------------------------------------
package psbl_pkg;

	localparam int THREADS = 16;
	localparam int LEVELS  = 8;
	localparam int TID_W   = 4;
	localparam int LVL_W   = 3;
	localparam int CNT_W   = 4;

	localparam logic [CNT_W-1:0] BURST_RESET = 4'd5;

	localparam logic [2:0] OP_START   = 3'd0;
	localparam logic [2:0] OP_READY   = 3'd1;
	localparam logic [2:0] OP_PREEMPT = 3'd2;
	localparam logic [2:0] OP_WAIT    = 3'd3;
	localparam logic [2:0] OP_SCHED   = 3'd4;

	localparam logic [1:0] TS_UNUSED  = 2'd0;
	localparam logic [1:0] TS_READY   = 2'd1;
	localparam logic [1:0] TS_RUNNING = 2'd2;
	localparam logic [1:0] TS_WAITING = 2'd3;

	typedef struct packed {
		logic [2:0]       op;
		logic [TID_W-1:0] thread_id;
		logic [LVL_W-1:0] priority_req;
	} in_t;

	typedef struct packed {
		logic             status;
		logic             idle;
		logic [TID_W-1:0] chosen_thread;
	} out_t;

	typedef enum logic [2:0] {
		CMD_START, CMD_READY, CMD_PREEMPT, CMD_WAIT, CMD_SCHED, CMD_BAD
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [TID_W-1:0] id;
		logic [LVL_W-1:0] lvl;
	} cmd_t;

endpackage

/* src/priority_scheduler_with_burst_limit_top.sv */
// A request word enters a decode register, waits in a two-entry command queue
// and is carried out by the back end, which owns the thread table and the
// ready queues. Start, ready, preempt and wait are carried out by the back end
// once the output is free. A schedule scans the priority levels from the
// highest down, one level per cycle, and then holds its result in a done state
// until the output is free. The front keeps accepting words while the back end
// works, until the queue is full.
// ----------------------------------------------------------------------------
// priority_scheduler_with_burst_limit_top
// Multilevel ready-queue scheduler with a per-level burst limit.
// ----------------------------------------------------------------------------
module priority_scheduler_with_burst_limit_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  psbl_pkg::in_t              in_word,
	output logic                       out_valid,
	input  logic                       out_stall,
	output psbl_pkg::out_t             out_word,
	input  logic                       cfg_we,
	input  logic [psbl_pkg::CNT_W-1:0] cfg_wdata
);

	logic           push, full, pop, q_valid;
	psbl_pkg::cmd_t f_cmd, q_cmd;

	psbl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.push     (push),
		.full     (full),
		.cmd      (f_cmd)
	);

	psbl_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (f_cmd),
		.full   (full),
		.pop    (pop),
		.valid  (q_valid),
		.rd_cmd (q_cmd)
	);

	psbl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (q_valid),
		.cmd       (q_cmd),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

/* src/psbl_front.sv */
// ----------------------------------------------------------------------------
// psbl_front
// Accepts request words, decodes the operation and hands commands on.
// ----------------------------------------------------------------------------
module psbl_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  psbl_pkg::in_t       in_word,
	output logic                push,
	input  logic                full,
	output psbl_pkg::cmd_t      cmd
);

	logic           v_s1;
	psbl_pkg::cmd_t cmd_s1;
	psbl_pkg::cmd_kind_t kind;
	logic           take;

	always_comb begin
		unique case (in_word.op)
			psbl_pkg::OP_START:   kind = psbl_pkg::CMD_START;
			psbl_pkg::OP_READY:   kind = psbl_pkg::CMD_READY;
			psbl_pkg::OP_PREEMPT: kind = psbl_pkg::CMD_PREEMPT;
			psbl_pkg::OP_WAIT:    kind = psbl_pkg::CMD_WAIT;
			psbl_pkg::OP_SCHED:   kind = psbl_pkg::CMD_SCHED;
			default:              kind = psbl_pkg::CMD_BAD;
		endcase
	end

	assign in_stall = v_s1 && full;
	assign take     = in_valid && !in_stall;
	assign push     = v_s1 && !full;
	assign cmd      = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= '{kind: kind, id: in_word.thread_id, lvl: in_word.priority_req};
		end
	end

endmodule

/* src/psbl_fifo.sv */
// ----------------------------------------------------------------------------
// psbl_fifo
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module psbl_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  psbl_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output psbl_pkg::cmd_t rd_cmd
);

	psbl_pkg::cmd_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full   = (count_q == 2'd2);
	assign valid  = (count_q != 2'd0);
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

/* src/psbl_back.sv */
// ----------------------------------------------------------------------------
// psbl_back
// Thread table, ready queues and the level scan that picks the next thread.
// ----------------------------------------------------------------------------
module psbl_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid,
	input  psbl_pkg::cmd_t                   cmd,
	output logic                             pop,
	input  logic                             cfg_we,
	input  logic [psbl_pkg::CNT_W-1:0]       cfg_wdata,
	output logic                             out_valid,
	input  logic                             out_stall,
	output psbl_pkg::out_t                   out_word
);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

	state_t st_q;
	logic [psbl_pkg::CNT_W-1:0] limit_q;
	logic [1:0]                 tstat_q [psbl_pkg::THREADS];
	logic [psbl_pkg::LVL_W-1:0] tlvl_q  [psbl_pkg::THREADS];
	logic [psbl_pkg::TID_W-1:0] link_q  [psbl_pkg::THREADS];
	logic [psbl_pkg::TID_W-1:0] head_q  [psbl_pkg::LEVELS];
	logic [psbl_pkg::TID_W-1:0] tail_q  [psbl_pkg::LEVELS];
	logic                       ne_q    [psbl_pkg::LEVELS];
	logic [psbl_pkg::CNT_W-1:0] cnt_q   [psbl_pkg::LEVELS];

	logic [psbl_pkg::LVL_W-1:0] lvl_q, sel_q, fb_q;
	logic                       selv_q, fbv_q;
	logic                       out_valid_q;
	psbl_pkg::out_t             out_q;

	logic out_free, exec, ok, append, set_wait, set_lvl;
	logic scan, trig, hit, defer, finish, pick;
	logic [1:0]                 cur_st;
	logic [psbl_pkg::LVL_W-1:0] lv_a;
	logic [psbl_pkg::TID_W-1:0] head_id;

	assign out_free = !out_valid_q || !out_stall;
	assign cur_st   = tstat_q[cmd.id];
	assign lv_a     = tlvl_q[cmd.id];
	assign head_id  = head_q[sel_q];

	always_comb begin
		unique case (cmd.kind)
			psbl_pkg::CMD_START:   ok = (cur_st == psbl_pkg::TS_UNUSED);
			psbl_pkg::CMD_READY:   ok = (cur_st == psbl_pkg::TS_WAITING);
			psbl_pkg::CMD_PREEMPT: ok = (cur_st == psbl_pkg::TS_RUNNING);
			psbl_pkg::CMD_WAIT:    ok = (cur_st == psbl_pkg::TS_RUNNING);
			default:               ok = 1'b0;
		endcase
	end

	assign exec     = (st_q == ST_IDLE) && valid && (cmd.kind != psbl_pkg::CMD_SCHED)
	                  && out_free;
	assign pop      = (st_q == ST_IDLE) && valid
	                  && ((cmd.kind == psbl_pkg::CMD_SCHED) || out_free);
	assign append   = exec && ok && ((cmd.kind == psbl_pkg::CMD_READY)
	                  || (cmd.kind == psbl_pkg::CMD_PREEMPT));
	assign set_lvl  = exec && ok && (cmd.kind == psbl_pkg::CMD_START);
	assign set_wait = set_lvl || (exec && ok && (cmd.kind == psbl_pkg::CMD_WAIT));

	// A level at its burst limit defers to the levels below it.
	assign scan   = (st_q == ST_SCAN);
	assign trig   = cnt_q[lvl_q] >= limit_q;
	assign hit    = scan && !trig && ne_q[lvl_q];
	assign defer  = trig && ne_q[lvl_q];
	assign finish = (st_q == ST_DONE) && out_free;
	assign pick   = finish && selv_q;

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= psbl_pkg::BURST_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < psbl_pkg::THREADS; i++) begin
				tstat_q[i] <= psbl_pkg::TS_UNUSED;
			end
			for (int i = 0; i < psbl_pkg::LEVELS; i++) begin
				ne_q[i]  <= 1'b0;
				cnt_q[i] <= '0;
			end
		end else begin
			if (set_wait) begin
				tstat_q[cmd.id] <= psbl_pkg::TS_WAITING;
			end
			if (append) begin
				tstat_q[cmd.id] <= psbl_pkg::TS_READY;
				ne_q[lv_a] <= 1'b1;
			end
			if (scan && (trig || !ne_q[lvl_q])) begin
				cnt_q[lvl_q] <= '0;
			end
			if (pick) begin
				tstat_q[head_id] <= psbl_pkg::TS_RUNNING;
				cnt_q[sel_q] <= cnt_q[sel_q] + 1'b1;
				if (head_id == tail_q[sel_q]) begin
					ne_q[sel_q] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (set_lvl) begin
			tlvl_q[cmd.id] <= cmd.lvl;
		end
		if (append) begin
			if (ne_q[lv_a]) begin
				link_q[tail_q[lv_a]] <= cmd.id;
			end else begin
				head_q[lv_a] <= cmd.id;
			end
			tail_q[lv_a] <= cmd.id;
		end
		if (pick && (head_id != tail_q[sel_q])) begin
			head_q[sel_q] <= link_q[head_id];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			lvl_q       <= '0;
			sel_q       <= '0;
			fb_q        <= '0;
			selv_q      <= 1'b0;
			fbv_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (exec || finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (exec) begin
						out_q <= '{status: !ok, idle: 1'b0, chosen_thread: '0};
					end else if (pop) begin
						lvl_q  <= psbl_pkg::LVL_W'(psbl_pkg::LEVELS - 1);
						fbv_q  <= 1'b0;
						st_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						sel_q  <= lvl_q;
						selv_q <= 1'b1;
						st_q   <= ST_DONE;
					end else begin
						if (defer) begin
							fb_q  <= lvl_q;
							fbv_q <= 1'b1;
						end
						if (lvl_q == '0) begin
							selv_q <= fbv_q || defer;
							sel_q  <= defer ? lvl_q : fb_q;
							st_q   <= ST_DONE;
						end else begin
							lvl_q <= lvl_q - 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (finish) begin
						out_q <= '{status: 1'b0, idle: !selv_q,
						           chosen_thread: selv_q ? head_id : '0};
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* src/psbl_checker.sv */
// ----------------------------------------------------------------------------
// psbl_checker
// Port-level checks on the scheduler's result words.
// ----------------------------------------------------------------------------
`include "priority_scheduler_with_burst_limit_top_assert.svh"

module psbl_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_stall,
	input psbl_pkg::out_t out_word
);

	`PSBL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`PSBL_ASSERT_NOW(a_idle_ok, out_valid && out_word.idle,
		!out_word.status && (out_word.chosen_thread == '0))
	`PSBL_ASSERT_NOW(a_reject_clean, out_valid && out_word.status,
		!out_word.idle && (out_word.chosen_thread == '0))

endmodule

bind priority_scheduler_with_burst_limit_top psbl_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the burst-limited priority scheduler: drives
// random and directed request words through the valid/stall channels and
// compares every response word against a behavioural scheduler model.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] OP_UNDEF_FIRST = 3'd5;
	localparam logic [2:0] OP_UNDEF_MID   = 3'd6;
	localparam logic [2:0] OP_UNDEF_LAST  = 3'd7;
	localparam int         NO_PICK        = -1;
	localparam int         CYCLE_LIMIT    = 600000;
	localparam int         SETTLE_CYCLES  = 20;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	psbl_pkg::in_t              in_word = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	psbl_pkg::out_t             out_word;
	logic                       cfg_we = 1'b0;
	logic [psbl_pkg::CNT_W-1:0] cfg_wdata = '0;

	int  fail_count = 0;
	int  cycle_count = 0;
	bit  no_gaps = 1'b0;
	psbl_pkg::out_t pending_resp[$];

	// scheduler model state
	logic [1:0]                 thr_state [psbl_pkg::THREADS];
	logic [psbl_pkg::LVL_W-1:0] thr_level [psbl_pkg::THREADS];
	logic [psbl_pkg::TID_W-1:0] thr_next  [psbl_pkg::THREADS];
	logic [psbl_pkg::TID_W-1:0] lvl_head  [psbl_pkg::LEVELS];
	logic [psbl_pkg::TID_W-1:0] lvl_tail  [psbl_pkg::LEVELS];
	bit                         lvl_busy  [psbl_pkg::LEVELS];
	logic [psbl_pkg::CNT_W-1:0] lvl_burst [psbl_pkg::LEVELS];
	logic [psbl_pkg::CNT_W-1:0] burst_lim;

	priority_scheduler_with_burst_limit_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic void enqueue_ready(int id);
		int lv;
		lv = int'(thr_level[id]);
		if (lvl_busy[lv])
			thr_next[lvl_tail[lv]] = id[psbl_pkg::TID_W-1:0];
		else begin
			lvl_head[lv] = id[psbl_pkg::TID_W-1:0];
			lvl_busy[lv] = 1'b1;
		end
		lvl_tail[lv] = id[psbl_pkg::TID_W-1:0];
	endfunction

	function automatic int dequeue_level(int lv);
		int h;
		if (!lvl_busy[lv])
			return NO_PICK;
		h = int'(lvl_head[lv]);
		if (lvl_head[lv] == lvl_tail[lv])
			lvl_busy[lv] = 1'b0;
		else
			lvl_head[lv] = thr_next[h];
		return h;
	endfunction

	// give lower levels one chance once a level has used up its burst
	function automatic int select_from(int lv);
		int lower, got;
		if (lv < 0)
			return NO_PICK;
		if (lvl_burst[lv] >= burst_lim) begin
			lower = select_from(lv - 1);
			lvl_burst[lv] = '0;
			if (lower != NO_PICK)
				return lower;
		end
		got = dequeue_level(lv);
		if (got == NO_PICK) begin
			lvl_burst[lv] = '0;
			return select_from(lv - 1);
		end
		lvl_burst[lv] = lvl_burst[lv] + 1'b1;
		return got;
	endfunction

	function automatic psbl_pkg::out_t schedule_step(psbl_pkg::in_t w);
		psbl_pkg::out_t r;
		int             t;
		logic [1:0]     need;
		r = '{status: 1'b1, idle: 1'b0, chosen_thread: '0};
		need = (w.op == psbl_pkg::OP_READY) ? psbl_pkg::TS_WAITING : psbl_pkg::TS_RUNNING;
		if (w.op == psbl_pkg::OP_SCHED) begin
			r.status = 1'b0;
			t = select_from(psbl_pkg::LEVELS - 1);
			if (t == NO_PICK)
				r.idle = 1'b1;
			else begin
				thr_state[t] = psbl_pkg::TS_RUNNING;
				r.chosen_thread = t[psbl_pkg::TID_W-1:0];
			end
		end else if (w.op == psbl_pkg::OP_START) begin
			if (thr_state[w.thread_id] == psbl_pkg::TS_UNUSED) begin
				thr_state[w.thread_id] = psbl_pkg::TS_WAITING;
				thr_level[w.thread_id] = w.priority_req;
				r.status = 1'b0;
			end
		end else if (w.op == psbl_pkg::OP_READY || w.op == psbl_pkg::OP_PREEMPT) begin
			if (thr_state[w.thread_id] == need) begin
				thr_state[w.thread_id] = psbl_pkg::TS_READY;
				enqueue_ready(int'(w.thread_id));
				r.status = 1'b0;
			end
		end else if (w.op == psbl_pkg::OP_WAIT) begin
			if (thr_state[w.thread_id] == psbl_pkg::TS_RUNNING) begin
				thr_state[w.thread_id] = psbl_pkg::TS_WAITING;
				r.status = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic psbl_pkg::in_t mk(logic [2:0] op, int id, int pr);
		psbl_pkg::in_t w;
		w.op = op;
		w.thread_id = id[psbl_pkg::TID_W-1:0];
		w.priority_req = pr[psbl_pkg::LVL_W-1:0];
		return w;
	endfunction

	// valid stays high after acceptance; a gap or a drain drops it
	task automatic send_word(psbl_pkg::in_t w);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (in_stall);
		pending_resp.push_back(schedule_step(w));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_resp.size() != 0) @(posedge clk);
	endtask

	task automatic write_burst_limit(logic [psbl_pkg::CNT_W-1:0] v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		burst_lim = v;
	endtask

	// mostly legal transitions for a random thread, with some noise
	task automatic send_random(int n);
		int            id, r;
		psbl_pkg::in_t w;
		repeat (n) begin
			r  = $urandom_range(0, 99);
			id = $urandom_range(0, psbl_pkg::THREADS - 1);
			if (r < 10)
				w = psbl_pkg::in_t'($urandom);
			else if (r < 40)
				w = mk(psbl_pkg::OP_SCHED, $urandom_range(0, 15), $urandom_range(0, 7));
			else begin
				unique case (thr_state[id])
					psbl_pkg::TS_UNUSED:
						w = mk(psbl_pkg::OP_START, id, $urandom_range(0, 7));
					psbl_pkg::TS_WAITING:
						w = mk(psbl_pkg::OP_READY, id, $urandom_range(0, 7));
					psbl_pkg::TS_RUNNING:
						w = mk(($urandom_range(0, 1) != 0) ? psbl_pkg::OP_PREEMPT
							: psbl_pkg::OP_WAIT, id, $urandom_range(0, 7));
					default:
						w = mk(psbl_pkg::OP_SCHED, id, $urandom_range(0, 7));
				endcase
			end
			send_word(w);
		end
	endtask

	task automatic test_directed();
		send_word(mk(psbl_pkg::OP_SCHED, 0, 0));     // nothing ready: idle
		send_word(mk(psbl_pkg::OP_READY, 3, 0));     // ready from unused: reject
		send_word(mk(psbl_pkg::OP_START, 0, 0));
		send_word(mk(psbl_pkg::OP_START, 15, 7));
		send_word(mk(psbl_pkg::OP_START, 15, 3));    // already started: reject
		send_word(mk(psbl_pkg::OP_START, 5, 7));
		send_word(mk(psbl_pkg::OP_PREEMPT, 0, 0));   // not running: reject
		send_word(mk(psbl_pkg::OP_WAIT, 0, 0));      // not running: reject
		send_word(mk(psbl_pkg::OP_READY, 0, 0));
		send_word(mk(psbl_pkg::OP_READY, 15, 7));
		send_word(mk(psbl_pkg::OP_READY, 5, 7));
		send_word(mk(OP_UNDEF_FIRST, 0, 0));
		send_word(mk(OP_UNDEF_MID, 15, 7));
		send_word(mk(OP_UNDEF_LAST, 5, 7));
		send_word(mk(psbl_pkg::OP_SCHED, 15, 7));
		send_word(mk(psbl_pkg::OP_PREEMPT, 15, 0));
		send_word(mk(psbl_pkg::OP_SCHED, 0, 0));
		send_word(mk(psbl_pkg::OP_WAIT, 5, 0));
		send_word(mk(psbl_pkg::OP_SCHED, 0, 0));
		send_word(mk(psbl_pkg::OP_SCHED, 0, 0));
		send_word(mk(psbl_pkg::OP_SCHED, 0, 0));
		send_word(mk(psbl_pkg::OP_READY, 5, 0));
		send_word(mk(psbl_pkg::OP_SCHED, 0, 0));
	endtask

	task automatic test_burst_limits();
		logic [psbl_pkg::CNT_W-1:0] limits [6];
		limits = '{4'd1, 4'd15, 4'd0, 4'd2, 4'd10, 4'd5};
		foreach (limits[i]) begin
			write_burst_limit(limits[i]);
			send_random(120);
		end
		write_burst_limit((psbl_pkg::CNT_W)'($urandom_range(0, 15)));
		send_random(120);
	endtask

	task automatic test_back_to_back();
		no_gaps = 1'b1;
		send_random(150);
		wait_drained();
		send_random(150);
		no_gaps = 1'b0;
	endtask

	task automatic test_random_mix();
		send_random(120);
		wait_drained();
		send_random(120);
	endtask

	// response side: random stall after each word, none while no_gaps is set
	initial begin : response_check
		int             hold;
		psbl_pkg::out_t want;
		hold = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_resp.size() == 0) begin
					$error("unexpected response word %h", out_word);
					fail_count++;
				end else begin
					want = pending_resp.pop_front();
					if (out_word.status !== want.status) begin
						$error("status: expected %0d actual %0d", want.status, out_word.status);
						fail_count++;
					end
					if (out_word.idle !== want.idle) begin
						$error("idle: expected %0d actual %0d", want.idle, out_word.idle);
						fail_count++;
					end
					if (out_word.chosen_thread !== want.chosen_thread) begin
						$error("chosen_thread: expected %0d actual %0d",
							want.chosen_thread, out_word.chosen_thread);
						fail_count++;
					end
				end
				hold = no_gaps ? 0 : $urandom_range(0, 7);
			end
			out_stall <= (hold > 0);
			if (hold > 0)
				hold--;
		end
	end

	initial begin
		foreach (thr_state[i]) begin
			thr_state[i] = psbl_pkg::TS_UNUSED;
			thr_level[i] = '0;
			thr_next[i]  = '0;
		end
		foreach (lvl_busy[i]) begin
			lvl_busy[i]  = 1'b0;
			lvl_burst[i] = '0;
			lvl_head[i]  = '0;
			lvl_tail[i]  = '0;
		end
		burst_lim = psbl_pkg::BURST_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		test_directed();
		test_burst_limits();
		test_back_to_back();
		test_random_mix();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+src
src/psbl_pkg.sv
src/psbl_front.sv
src/psbl_fifo.sv
src/psbl_back.sv
src/priority_scheduler_with_burst_limit_top.sv
src/psbl_checker.sv
tb/tb.sv
